FILE: sv/cxsc_pkg.sv
// shared types, codes and key helpers for the chained xor stream cipher framer
package cxsc_pkg;

  // key store and register map
  localparam int KeyBytes = 32;
  localparam int KeyW     = 8 * KeyBytes;
  localparam int NumRegs  = 6;
  localparam int AddrW    = $clog2(NumRegs * 8);
  localparam int DataW    = 64;
  localparam int LenW     = 6;
  localparam int PosW     = 6;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_KEY_LEN = 3'd1;
  localparam logic [2:0] REG_KEY_W0  = 3'd2;
  localparam logic [2:0] REG_KEY_W1  = 3'd3;
  localparam logic [2:0] REG_KEY_W2  = 3'd4;
  localparam logic [2:0] REG_KEY_W3  = 3'd5;

  // input commands
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_EXT   = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;
  localparam logic [1:0] CMD_PAY   = 2'd3;

  // result kinds and status codes
  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_EXT = 2'd1;
  localparam logic [1:0] KIND_SEP = 2'd2;
  localparam logic [1:0] KIND_PAY = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_VALID    = 2'd1;
  localparam logic [1:0] STAT_MISMATCH = 2'd2;

  // frame phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_ENC_EXT  = 3'd1;
  localparam logic [2:0] PH_ENC_PAY  = 3'd2;
  localparam logic [2:0] PH_DEC_HDR  = 3'd3;
  localparam logic [2:0] PH_DEC_EXT  = 3'd4;
  localparam logic [2:0] PH_DEC_PAY  = 3'd5;
  localparam logic [2:0] PH_DEC_FAIL = 3'd6;

  localparam logic [7:0] Separator = 8'd30;

  typedef struct packed {
    logic              mode;
    logic [LenW-1:0]   key_length;
    logic [KeyW-1:0]   key;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic frame_init;
    logic wsum_step;
    logic hdr_step;
    logic mod_start;
    logic mod_step;
    logic item_step;
    logic use_rem;
  } dp_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic is_begin;
    logic act;
    logic emit;
    logic need_mod;
    logic cnt_last;
    logic mod_last;
    logic out_free;
    logic mode;
  } dp_sts_t;

  // key byte at an index, zero past the key store
  function automatic logic [7:0] key_byte(input logic [KeyW-1:0] key,
                                          input logic [PosW-1:0] idx);
    logic [7:0] b;
    b = 8'd0;
    if (idx < PosW'(KeyBytes)) begin
      b = key[{idx[4:0], 3'b000} +: 8];
    end
    return b;
  endfunction

  // key length clamped to one through the key store size
  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] kl);
    logic [LenW-1:0] l;
    l = kl;
    if (kl == '0) begin
      l = LenW'(1);
    end else if (kl > LenW'(KeyBytes)) begin
      l = LenW'(KeyBytes);
    end
    return l;
  endfunction

endpackage

FILE: sv/cxsc_regs.sv
// apb configuration registers: mode, key length and key words
module cxsc_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cxsc_pkg::AddrW-1:0] paddr,
  input  logic [cxsc_pkg::DataW-1:0] pwdata,
  output logic [cxsc_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output cxsc_pkg::cfg_t             cfg_o
);
  import cxsc_pkg::*;

  logic            mode_q;
  logic [LenW-1:0] klen_q;
  logic [KeyW-1:0] key_q;
  logic            wr_en;
  logic [2:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrW-1:3];

  // register writes on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      klen_q <= LenW'(1);
      key_q  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE:    mode_q <= pwdata[0];
        REG_KEY_LEN: klen_q <= pwdata[LenW-1:0];
        REG_KEY_W0:  key_q[0*DataW +: DataW] <= pwdata;
        REG_KEY_W1:  key_q[1*DataW +: DataW] <= pwdata;
        REG_KEY_W2:  key_q[2*DataW +: DataW] <= pwdata;
        REG_KEY_W3:  key_q[3*DataW +: DataW] <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_MODE:    prdata = {{(DataW-1){1'b0}}, mode_q};
      REG_KEY_LEN: prdata = {{(DataW-LenW){1'b0}}, klen_q};
      REG_KEY_W0:  prdata = key_q[0*DataW +: DataW];
      REG_KEY_W1:  prdata = key_q[1*DataW +: DataW];
      REG_KEY_W2:  prdata = key_q[2*DataW +: DataW];
      REG_KEY_W3:  prdata = key_q[3*DataW +: DataW];
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.mode       = mode_q;
  assign cfg_o.key_length = klen_q;
  assign cfg_o.key        = key_q;

endmodule

FILE: sv/cxsc_ctrl.sv
// controller state machine sequencing begin, header, remainder and byte steps
module cxsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cxsc_pkg::dp_sts_t sts_i,
  output cxsc_pkg::dp_ctl_t ctl_o
);
  import cxsc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WSUM = 3'd2;
  localparam logic [2:0] S_HDR  = 3'd3;
  localparam logic [2:0] S_MOD  = 3'd4;
  localparam logic [2:0] S_STEP = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.is_begin) begin
          ctl_o.frame_init = 1'b1;
          state_d          = S_WSUM;
        end else if (!sts_i.act) begin
          state_d = S_IDLE;
        end else if (sts_i.need_mod) begin
          ctl_o.mod_start = 1'b1;
          state_d         = S_MOD;
        end else if (!sts_i.emit || sts_i.out_free) begin
          ctl_o.item_step = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_MOD: begin
        ctl_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        ctl_o.use_rem = 1'b1;
        if (!sts_i.emit || sts_i.out_free) begin
          ctl_o.item_step = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_WSUM: begin
        ctl_o.wsum_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = sts_i.mode ? S_IDLE : S_HDR;
        end
      end
      S_HDR: begin
        if (sts_i.out_free) begin
          ctl_o.hdr_step = 1'b1;
          if (sts_i.cnt_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: sv/cxsc_dp.sv
// datapath: frame state, chained xor, key remainder unit and output register
module cxsc_dp #(
  parameter int EXT_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cxsc_pkg::cfg_t    cfg_i,
  input  cxsc_pkg::dp_ctl_t ctl_i,
  output cxsc_pkg::dp_sts_t sts_o,
  input  logic [1:0]        cmd_i,
  input  logic [7:0]        data_in_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        data_out_o,
  output logic [1:0]        kind_o,
  output logic [1:0]        status_o,
  output logic              last_o
);
  import cxsc_pkg::*;

  localparam int ExtW = $clog2(EXT_BYTES + 1);

  // latched input item
  logic [1:0]      cmd_q;
  logic [7:0]      x_q;
  // frame state
  logic [2:0]      phase_q;
  logic [7:0]      prev_q;
  logic [PosW-1:0] pos_q;
  logic [LenW-1:0] hcnt_q;
  logic [ExtW-1:0] ecnt_q;
  logic [7:0]      weight_q;
  logic [LenW-1:0] cnt_q;
  // remainder unit
  logic [PosW-1:0] rem_q;
  logic [2:0]      mcnt_q;
  // output register
  logic            out_valid_q;
  logic [7:0]      out_data_q;
  logic [1:0]      out_kind_q;
  logic [1:0]      out_stat_q;
  logic            out_last_q;

  logic [LenW-1:0] len;
  logic [PosW:0]   pos_inc;
  logic [PosW-1:0] pos_next;
  logic [PosW-1:0] kidx;
  logic [7:0]      kb;
  logic [7:0]      hdr_src;
  logic [LenW-1:0] hc;
  logic [7:0]      hdr_exp;
  logic [7:0]      xin;
  logic [7:0]      y;
  logic [7:0]      hdr_y;
  logic [PosW:0]   rem_sh;
  logic            out_free;
  logic            out_load;

  logic            act, emit;
  logic [1:0]      res_kind, res_stat;
  logic [2:0]      ph_next;
  logic [7:0]      prev_next;
  logic [LenW-1:0] hcnt_next;
  logic [ExtW-1:0] ecnt_next;
  logic [ExtW:0]   ecnt_inc;

  assign len      = eff_len(cfg_i.key_length);
  assign pos_inc  = {1'b0, pos_q} + (PosW+1)'(1);
  assign pos_next = (pos_inc >= {1'b0, len}) ? '0 : pos_inc[PosW-1:0];
  assign kidx     = ctl_i.use_rem ? rem_q : pos_q;
  assign kb       = key_byte(cfg_i.key, kidx);
  assign hdr_src  = key_byte(cfg_i.key, len - LenW'(1) - cnt_q);
  assign hc       = (hcnt_q < len) ? hcnt_q : len - LenW'(1);
  assign hdr_exp  = key_byte(cfg_i.key, len - LenW'(1) - hc);
  assign xin      = (phase_q == PH_ENC_EXT && cmd_q == CMD_END) ? Separator : x_q;
  assign y        = xin ^ prev_q ^ kb ^ weight_q;
  assign hdr_y    = hdr_src ^ prev_q ^ kb ^ weight_q;
  assign ecnt_inc = {1'b0, ecnt_q} + (ExtW+1)'(1);
  assign rem_sh   = {rem_q, pos_q[mcnt_q]};
  assign out_free = !out_valid_q || out_ready_i;

  // per-phase decision for one byte item
  always_comb begin
    act       = 1'b0;
    emit      = 1'b0;
    res_kind  = KIND_PAY;
    res_stat  = STAT_OK;
    ph_next   = phase_q;
    prev_next = prev_q;
    hcnt_next = hcnt_q;
    ecnt_next = ecnt_q;
    case (phase_q)
      PH_ENC_EXT: begin
        prev_next = xin;
        if (cmd_q == CMD_EXT && ecnt_q < ExtW'(EXT_BYTES)) begin
          act       = 1'b1;
          emit      = 1'b1;
          res_kind  = KIND_EXT;
          ecnt_next = ecnt_inc[ExtW-1:0];
        end else if (cmd_q == CMD_END) begin
          act      = 1'b1;
          emit     = 1'b1;
          res_kind = KIND_SEP;
          ph_next  = PH_ENC_PAY;
        end
      end
      PH_ENC_PAY: begin
        prev_next = xin;
        if (cmd_q == CMD_PAY) begin
          act  = 1'b1;
          emit = 1'b1;
        end
      end
      PH_DEC_HDR: begin
        prev_next = y;
        act       = (cmd_q == CMD_EXT) || (cmd_q == CMD_PAY);
        res_kind  = KIND_HDR;
        if (y != hdr_exp) begin
          emit     = 1'b1;
          res_stat = STAT_MISMATCH;
          ph_next  = PH_DEC_FAIL;
        end else begin
          hcnt_next = hcnt_q + LenW'(1);
          if (hc == len - LenW'(1)) begin
            emit     = 1'b1;
            res_stat = STAT_VALID;
            ph_next  = PH_DEC_EXT;
          end
        end
      end
      PH_DEC_EXT: begin
        prev_next = y;
        act       = (cmd_q == CMD_EXT) || (cmd_q == CMD_PAY);
        emit      = 1'b1;
        ecnt_next = ecnt_inc[ExtW-1:0];
        if (y == Separator) begin
          res_kind = KIND_SEP;
          ph_next  = PH_DEC_PAY;
        end else begin
          res_kind = KIND_EXT;
          if (ecnt_inc >= (ExtW+1)'(EXT_BYTES)) begin
            ph_next = PH_DEC_PAY;
          end
        end
      end
      PH_DEC_PAY: begin
        prev_next = y;
        act       = (cmd_q == CMD_EXT) || (cmd_q == CMD_PAY);
        emit      = 1'b1;
      end
      default: ;
    endcase
  end

  // input latch
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      cmd_q <= cmd_i;
      x_q   <= data_in_i;
    end
  end

  // frame state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      prev_q   <= '0;
      pos_q    <= '0;
      hcnt_q   <= '0;
      ecnt_q   <= '0;
      weight_q <= '0;
      cnt_q    <= '0;
    end else if (ctl_i.frame_init) begin
      prev_q   <= '0;
      pos_q    <= '0;
      hcnt_q   <= '0;
      ecnt_q   <= '0;
      weight_q <= '0;
      cnt_q    <= '0;
    end else if (ctl_i.wsum_step) begin
      weight_q <= weight_q + key_byte(cfg_i.key, cnt_q);
      if (cnt_q == len - LenW'(1)) begin
        cnt_q   <= '0;
        phase_q <= cfg_i.mode ? PH_DEC_HDR : PH_ENC_EXT;
      end else begin
        cnt_q <= cnt_q + LenW'(1);
      end
    end else if (ctl_i.hdr_step) begin
      prev_q <= hdr_src;
      pos_q  <= pos_next;
      cnt_q  <= cnt_q + LenW'(1);
    end else if (ctl_i.item_step) begin
      prev_q  <= prev_next;
      pos_q   <= pos_next;
      phase_q <= ph_next;
      hcnt_q  <= hcnt_next;
      ecnt_q  <= ecnt_next;
    end
  end

  // bit-serial remainder of key position by key length, msb first
  always_ff @(posedge clk_i) begin
    if (ctl_i.mod_start) begin
      rem_q  <= '0;
      mcnt_q <= 3'(PosW - 1);
    end else if (ctl_i.mod_step) begin
      rem_q  <= (rem_sh >= {1'b0, len}) ? PosW'(rem_sh - {1'b0, len})
                                        : rem_sh[PosW-1:0];
      mcnt_q <= mcnt_q - 3'd1;
    end
  end

  // output register, refilled in the cycle the current result transfers
  assign out_load = ctl_i.hdr_step || (ctl_i.item_step && emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.hdr_step) begin
      out_data_q <= hdr_y;
      out_kind_q <= KIND_HDR;
      out_stat_q <= STAT_OK;
      out_last_q <= (cnt_q == len - LenW'(1));
    end else if (ctl_i.item_step && emit) begin
      out_data_q <= y;
      out_kind_q <= res_kind;
      out_stat_q <= res_stat;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;
  assign kind_o      = out_kind_q;
  assign status_o    = out_stat_q;
  assign last_o      = out_last_q;

  // status back to the controller
  assign sts_o.is_begin = (cmd_q == CMD_BEGIN);
  assign sts_o.act      = act;
  assign sts_o.emit     = emit;
  assign sts_o.need_mod = (pos_q >= len);
  assign sts_o.cnt_last = (cnt_q == len - LenW'(1));
  assign sts_o.mod_last = (mcnt_q == 3'd0);
  assign sts_o.out_free = out_free;
  assign sts_o.mode     = cfg_i.mode;

endmodule

FILE: sv/chained_xor_stream_cipher_framer.sv
// top level of the chained xor stream cipher framer
//
// Input channel (in_valid_i/in_ready_o) carries cmd_i and data_in_i; each
// transfer is one command: begin, extension byte, end of extension, payload byte.
// Output channel (out_valid_o/out_ready_i) carries data_out_o, kind_o, status_o
// and last_o; last_o marks the final result of a command.
// The APB port sets mode, key length and four 64-bit key words at 8-byte steps;
// write it only while the block is idle between frames or items.
// A byte command is accepted in the idle state and its xor step runs in the
// execute state; no new command is taken until the step is done, and the
// result is loaded into the output register. When the key position has outgrown
// a shortened key, a bit-serial remainder unit runs before the step.
// A begin sums the key bytes one per cycle; in encrypt mode it then emits the
// header, one byte per cycle while the output register is free.
// A single output register holds the pending result; the next command is taken
// while it waits, but a step that has a result waits until that register frees.
// A receiver stall therefore holds the block without losing or repeating data.
// Reset returns the frame to idle and clears the registers to their defaults;
// no clearing pass is needed.
module chained_xor_stream_cipher_framer #(
  parameter int EXT_BYTES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cxsc_pkg::AddrW-1:0] paddr,
  input  logic [cxsc_pkg::DataW-1:0] pwdata,
  output logic [cxsc_pkg::DataW-1:0] prdata,
  output logic                       pready,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 cmd_i,
  input  logic [7:0]                 data_in_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 data_out_o,
  output logic [1:0]                 kind_o,
  output logic [1:0]                 status_o,
  output logic                       last_o
);
  import cxsc_pkg::*;

  cfg_t    cfg;
  dp_ctl_t dp_ctl;
  dp_sts_t dp_sts;

  // configuration registers
  cxsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // controller
  cxsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .ctl_o      (dp_ctl)
  );

  // datapath
  cxsc_dp #(
    .EXT_BYTES (EXT_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .ctl_i       (dp_ctl),
    .sts_o       (dp_sts),
    .cmd_i       (cmd_i),
    .data_in_i   (data_in_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .data_out_o  (data_out_o),
    .kind_o      (kind_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  // the block is busy in the cycle after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a command is still executing");

  // at most one datapath operation per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({dp_ctl.frame_init, dp_ctl.wsum_step, dp_ctl.hdr_step,
              dp_ctl.mod_start, dp_ctl.mod_step, dp_ctl.item_step}))
    else $error("conflicting datapath commands");

  // a result is only loaded when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_ctl.hdr_step || (dp_ctl.item_step && dp_sts.emit)) |-> dp_sts.out_free)
    else $error("output register overwritten");

  // header positions never run past the key length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_ctl.hdr_step |-> !dp_sts.need_mod)
    else $error("key position out of range during header");

endmodule

FILE: test/chained_xor_stream_cipher_framer_checker.sv
// result checker for the chained xor stream cipher framer: predicts every result and compares
module chained_xor_stream_cipher_framer_checker #(
  parameter int EXT_BYTES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port, watched for register writes
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [cxsc_pkg::AddrW-1:0] paddr,
  input  logic [cxsc_pkg::DataW-1:0] pwdata,
  // input channel
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [1:0]                 cmd_i,
  input  logic [7:0]                 data_in_i,
  // output channel
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [7:0]                 data_out_i,
  input  logic [1:0]                 kind_i,
  input  logic [1:0]                 status_i,
  input  logic                       last_i,
  // to the testbench top
  output int                         errors_o,
  output int                         pending_o
);
  import cxsc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [1:0] status;
    logic       last;
  } cipher_res_t;

  // shadow registers
  logic        mode_r;
  logic [5:0]  klen_r;
  logic [63:0] kword [4];

  // shadow frame state
  logic [2:0]  phase;
  logic [7:0]  prev_b;
  logic [7:0]  weight;
  int unsigned kpos;
  int unsigned hcnt;
  int unsigned ecnt;

  cipher_res_t expected_bytes [$];
  int          err_n;

  // key length clamped to the key store
  function automatic int unsigned span_len();
    int unsigned l;
    l = klen_r;
    if (l < 1) l = 1;
    if (l > KeyBytes) l = KeyBytes;
    return l;
  endfunction

  // key byte, zero past the store
  function automatic logic [7:0] key_octet(int unsigned k);
    if (k >= KeyBytes) return 8'd0;
    return kword[k / 8][8 * (k % 8) +: 8];
  endfunction

  // one chained xor step, advances the key position
  function automatic logic [7:0] mix(logic [7:0] x);
    int unsigned l;
    logic [7:0]  y;
    l = span_len();
    y = x ^ prev_b ^ key_octet(kpos % l) ^ weight;
    kpos = kpos + 1;
    if (kpos >= l) kpos = 0;
    return y;
  endfunction

  function automatic cipher_res_t mk(logic [7:0] d, logic [1:0] k, logic [1:0] s);
    cipher_res_t r;
    r.data   = d;
    r.kind   = k;
    r.status = s;
    r.last   = 1'b0;
    return r;
  endfunction

  // expected results of one accepted command
  task automatic predict_frame_step(logic [1:0] cmd, logic [7:0] x);
    cipher_res_t res [32];
    int          n;
    int unsigned l;
    int unsigned hc;
    logic [7:0]  p;
    logic [7:0]  d;
    n = 0;
    l = span_len();
    if (cmd == CMD_BEGIN) begin
      weight = 8'd0;
      for (int unsigned k = 0; k < l; k++) weight = weight + key_octet(k);
      prev_b = 8'd0;
      kpos   = 0;
      hcnt   = 0;
      ecnt   = 0;
      if (mode_r == 1'b0) begin
        // reversed key goes out as the header
        for (int unsigned k = 0; k < l; k++) begin
          p = key_octet(l - 1 - k);
          res[n] = mk(mix(p), KIND_HDR, STAT_OK);
          n++;
          prev_b = p;
        end
        phase = PH_ENC_EXT;
      end else begin
        phase = PH_DEC_HDR;
      end
    end else if (phase == PH_ENC_EXT) begin
      if (cmd == CMD_EXT && ecnt < EXT_BYTES) begin
        res[n] = mk(mix(x), KIND_EXT, STAT_OK);
        n++;
        prev_b = x;
        ecnt++;
      end else if (cmd == CMD_END) begin
        res[n] = mk(mix(Separator), KIND_SEP, STAT_OK);
        n++;
        prev_b = Separator;
        phase  = PH_ENC_PAY;
      end
    end else if (phase == PH_ENC_PAY) begin
      if (cmd == CMD_PAY) begin
        res[n] = mk(mix(x), KIND_PAY, STAT_OK);
        n++;
        prev_b = x;
      end
    end else if (cmd == CMD_EXT || cmd == CMD_PAY) begin
      if (phase == PH_DEC_HDR) begin
        // header check against the reversed key
        hc = (hcnt < l) ? hcnt : l - 1;
        d = mix(x);
        prev_b = d;
        if (d != key_octet(l - 1 - hc)) begin
          res[n] = mk(d, KIND_HDR, STAT_MISMATCH);
          n++;
          phase = PH_DEC_FAIL;
        end else begin
          hcnt = (hcnt + 1) & 63;
          if (hc + 1 >= l) begin
            res[n] = mk(d, KIND_HDR, STAT_VALID);
            n++;
            phase = PH_DEC_EXT;
          end
        end
      end else if (phase == PH_DEC_EXT) begin
        d = mix(x);
        prev_b = d;
        ecnt++;
        if (d == Separator) begin
          res[n] = mk(d, KIND_SEP, STAT_OK);
          n++;
          phase = PH_DEC_PAY;
        end else begin
          res[n] = mk(d, KIND_EXT, STAT_OK);
          n++;
          if (ecnt >= EXT_BYTES) phase = PH_DEC_PAY;
        end
      end else if (phase == PH_DEC_PAY) begin
        d = mix(x);
        prev_b = d;
        res[n] = mk(d, KIND_PAY, STAT_OK);
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) res[i].last = 1'b1;
      expected_bytes.push_back(res[i]);
    end
  endtask

  // compare one output transfer with the oldest expectation
  task automatic check_result();
    cipher_res_t want;
    if (expected_bytes.size() == 0) begin
      err_n++;
      if (err_n <= 10) begin
        $display("unexpected result: data %h kind %0d status %0d last %0b",
                 data_out_i, kind_i, status_i, last_i);
      end
    end else begin
      want = expected_bytes.pop_front();
      if (want.data != data_out_i || want.kind != kind_i ||
          want.status != status_i || want.last != last_i) begin
        err_n++;
        if (err_n <= 10) begin
          $display("mismatch: expected data %h kind %0d status %0d last %0b,",
                   want.data, want.kind, want.status, want.last);
          $display("          got data %h kind %0d status %0d last %0b",
                   data_out_i, kind_i, status_i, last_i);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_r = 1'b0;
      klen_r = 6'd1;
      for (int i = 0; i < 4; i++) kword[i] = '0;
      phase  = PH_IDLE;
      prev_b = 8'd0;
      weight = 8'd0;
      kpos   = 0;
      hcnt   = 0;
      ecnt   = 0;
      err_n  = 0;
      expected_bytes.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1:3])
          REG_MODE:    mode_r = pwdata[0];
          REG_KEY_LEN: klen_r = pwdata[5:0];
          REG_KEY_W0:  kword[0] = pwdata;
          REG_KEY_W1:  kword[1] = pwdata;
          REG_KEY_W2:  kword[2] = pwdata;
          REG_KEY_W3:  kword[3] = pwdata;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) predict_frame_step(cmd_i, data_in_i);
      errors_o  <= err_n;
      pending_o <= expected_bytes.size();
    end
  end

endmodule

FILE: test/chained_xor_stream_cipher_framer_test.sv
// testbench top for the chained xor stream cipher framer: stimulus, idling and verdict
module chained_xor_stream_cipher_framer_test;
  import cxsc_pkg::*;

  localparam int ExtBytes  = 8;
  localparam int SettleCyc = 100;
  localparam int HoldCyc   = 300;
  localparam int CycLimit  = 600000;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [AddrW-1:0] paddr     = '0;
  logic [DataW-1:0] pwdata    = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [1:0]       cmd       = CMD_BEGIN;
  logic [7:0]       data_in   = 8'd0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       data_out;
  logic [1:0]       kind;
  logic [1:0]       status;
  logic             last;

  int fail_n;
  int pending_n;

  // idling and hold-off controls
  int send_idle_pct = 15;
  int recv_idle_pct = 65;
  int hold_asks     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycle_n       = 0;
  int sent_n        = 0;

  // register copies for building ciphertext
  logic        t_mode = 1'b0;
  logic [5:0]  t_len  = 6'd1;
  logic [63:0] t_key [4] = '{default: '0};

  // ciphertext generator state for decrypt frames
  logic [7:0]  g_prev = 8'd0;
  logic [7:0]  g_w    = 8'd0;
  int unsigned g_pos  = 0;
  int unsigned g_hcnt = 0;

  chained_xor_stream_cipher_framer #(
    .EXT_BYTES(ExtBytes)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .cmd_i      (cmd),
    .data_in_i  (data_in),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .data_out_o (data_out),
    .kind_o     (kind),
    .status_o   (status),
    .last_o     (last)
  );

  chained_xor_stream_cipher_framer_checker #(
    .EXT_BYTES(ExtBytes)
  ) checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .cmd_i      (cmd),
    .data_in_i  (data_in),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .data_out_i (data_out),
    .kind_i     (kind),
    .status_i   (status),
    .last_i     (last),
    .errors_o   (fail_n),
    .pending_o  (pending_n)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CycLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls plus requested long hold-offs
  always @(posedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HoldCyc;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic int unsigned gen_len();
    int unsigned l;
    l = t_len;
    if (l < 1) l = 1;
    if (l > KeyBytes) l = KeyBytes;
    return l;
  endfunction

  function automatic logic [7:0] gen_key(int unsigned k);
    if (k >= KeyBytes) return 8'd0;
    return t_key[k / 8][8 * (k % 8) +: 8];
  endfunction

  function automatic logic [1:0] byte_cmd();
    return $urandom_range(1) ? CMD_PAY : CMD_EXT;
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(logic [1:0] c, logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    data_in  <= d;
    do @(posedge clk_i); while (!in_ready);
    sent_n++;
  endtask

  // register write: setup cycle, access cycle
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_MODE:    t_mode = val[0];
      REG_KEY_LEN: t_len = val[5:0];
      REG_KEY_W0:  t_key[0] = val;
      REG_KEY_W1:  t_key[1] = val;
      REG_KEY_W2:  t_key[2] = val;
      REG_KEY_W3:  t_key[3] = val;
      default: ;
    endcase
  endtask

  // stop sending, wait for every expected result, then let the block settle
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_n != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // begin, with the generator restarted for a decrypt frame
  task automatic gen_begin();
    int unsigned l;
    l   = gen_len();
    g_w = 8'd0;
    for (int unsigned k = 0; k < l; k++) g_w = g_w + gen_key(k);
    g_prev = 8'd0;
    g_pos  = 0;
    g_hcnt = 0;
    send_item(CMD_BEGIN, 8'($urandom));
  endtask

  // send the ciphertext that deciphers to a given plain byte
  task automatic send_cipher(logic [1:0] c, logic [7:0] plain);
    int unsigned l;
    logic [7:0]  x;
    l = gen_len();
    x = plain ^ g_prev ^ gen_key(g_pos % l) ^ g_w;
    g_pos = g_pos + 1;
    if (g_pos >= l) g_pos = 0;
    g_prev = plain;
    send_item(c, x);
  endtask

  // next header byte, good or corrupted
  task automatic send_hdr_byte(bit corrupt);
    int unsigned l;
    int unsigned hc;
    logic [7:0]  p;
    l  = gen_len();
    hc = (g_hcnt < l) ? g_hcnt : l - 1;
    p  = gen_key(l - 1 - hc);
    if (corrupt) p = p ^ 8'($urandom_range(1, 255));
    g_hcnt++;
    send_cipher(byte_cmd(), p);
  endtask

  // well-formed encrypt frame with random content
  task automatic enc_frame();
    int n;
    send_item(CMD_BEGIN, 8'($urandom));
    n = $urandom_range(0, 10);
    repeat (n) send_item(CMD_EXT, 8'($urandom));
    send_item(CMD_END, 8'($urandom));
    n = $urandom_range(1, 8);
    repeat (n) send_item(CMD_PAY, 8'($urandom));
  endtask

  // decrypt frame: good header mostly, sometimes one bad header byte
  task automatic dec_frame();
    int unsigned l;
    int          bad;
    int          n;
    gen_begin();
    l   = gen_len();
    bad = ($urandom_range(9) == 0) ? int'($urandom_range(l - 1)) : -1;
    for (int i = 0; i < l; i++) begin
      send_hdr_byte(i == bad);
      if (i == bad) break;
    end
    if (bad >= 0) begin
      n = $urandom_range(1, 3);
      repeat (n) send_cipher(byte_cmd(), 8'($urandom));
    end else begin
      n = $urandom_range(0, ExtBytes);
      repeat (n) send_cipher(CMD_EXT, 8'($urandom));
      if (n < ExtBytes) send_cipher(CMD_EXT, Separator);
      n = $urandom_range(1, 8);
      repeat (n) send_cipher(byte_cmd(), 8'($urandom));
    end
  endtask

  // raw commands in any order
  task automatic noise_frame();
    int n;
    n = $urandom_range(1, 5);
    repeat (n) send_item(2'($urandom), 8'($urandom));
  endtask

  function automatic logic [63:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return {$urandom, $urandom};
  endfunction

  // new register settings, small key lengths mostly
  task automatic pick_config();
    int r;
    quiesce();
    write_reg(REG_MODE, 64'($urandom_range(1)));
    r = $urandom_range(99);
    if (r < 8) write_reg(REG_KEY_LEN, 64'd0);
    else if (r < 16) write_reg(REG_KEY_LEN, 64'd32);
    else if (r < 22) write_reg(REG_KEY_LEN, 64'($urandom_range(33, 63)));
    else write_reg(REG_KEY_LEN, 64'($urandom_range(1, 6)));
    if ($urandom_range(1)) begin
      write_reg(REG_KEY_W0, pick_word());
      write_reg(REG_KEY_W1, pick_word());
      write_reg(REG_KEY_W2, pick_word());
      write_reg(REG_KEY_W3, pick_word());
    end
  endtask

  initial begin
    int target;
    int r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero key length runs as one, all-ones key
    write_reg(REG_MODE, 64'd0);
    write_reg(REG_KEY_LEN, 64'd0);
    write_reg(REG_KEY_W0, '1);
    write_reg(REG_KEY_W1, {$urandom, $urandom});
    write_reg(REG_KEY_W2, {$urandom, $urandom});
    write_reg(REG_KEY_W3, {$urandom, $urandom});
    // payload before begin and extension after end are dropped
    send_item(CMD_PAY, 8'h5a);
    send_item(CMD_BEGIN, 8'h00);
    send_item(CMD_EXT, 8'h00);
    send_item(CMD_EXT, 8'hff);
    send_item(CMD_END, 8'hff);
    send_item(CMD_EXT, 8'h12);
    send_item(CMD_PAY, 8'h00);
    send_item(CMD_PAY, 8'hff);

    // oversized key length clamps to the full key, extension overflow dropped
    quiesce();
    write_reg(REG_KEY_LEN, 64'd63);
    write_reg(REG_KEY_W3, '0);
    send_item(CMD_BEGIN, 8'hff);
    repeat (ExtBytes + 1) send_item(CMD_EXT, 8'($urandom));
    send_item(CMD_END, 8'h00);
    send_item(CMD_PAY, 8'($urandom));
    // shorter key inside the frame: key position wraps by the new length
    quiesce();
    write_reg(REG_KEY_LEN, 64'd5);
    send_item(CMD_PAY, 8'ha5);

    // decrypt, key shortened mid-header so the header completes early
    quiesce();
    write_reg(REG_MODE, 64'd1);
    write_reg(REG_KEY_LEN, 64'd6);
    gen_begin();
    repeat (3) send_hdr_byte(1'b0);
    quiesce();
    write_reg(REG_KEY_LEN, 64'd4);
    send_hdr_byte(1'b0);
    send_item(CMD_END, 8'h00);
    send_cipher(CMD_EXT, 8'h41);
    send_cipher(CMD_PAY, Separator);
    send_cipher(CMD_PAY, 8'h00);
    // bad header byte, then silence
    gen_begin();
    send_hdr_byte(1'b1);
    send_cipher(CMD_PAY, 8'hff);

    // random frames under three idling settings
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct <= 65;
        recv_idle_pct <= 15;
      end else if (ph == 2) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        // long receiver hold-off while a full header is offered
        quiesce();
        write_reg(REG_MODE, 64'd0);
        write_reg(REG_KEY_LEN, 64'd32);
        hold_asks <= hold_asks + 1;
        enc_frame();
      end
      target = sent_n + 35;
      while (sent_n < target) begin
        if ($urandom_range(3) == 0) pick_config();
        r = $urandom_range(99);
        if (r < 15) noise_frame();
        else if (t_mode) dec_frame();
        else enc_frame();
      end
    end

    quiesce();
    if (fail_n == 0 && pending_n == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
